// ----- hdl/spq_pkg.sv -----
// shared types, widths and codes for the strict priority multi-queue
package spq_pkg;

    // default sizes handed to the top level parameters
    localparam int NUM_LEVELS_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 16;

    // request and response field widths
    localparam int KIND_W   = 2;
    localparam int TID_W    = 16;
    localparam int PRIO_W   = 4;
    localparam int TOTC_W   = 8;
    localparam int LVLC_W   = 5;
    localparam int STATUS_W = 2;

    // configuration port
    localparam int CFG_W     = 4;
    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = 3;
    localparam logic [CFG_W-1:0] LEVELS_RST = 4'd8;
    localparam logic             REG_LEVELS = 1'b0;

    // request kinds, any other code acts as a peek
    localparam logic [KIND_W-1:0] KIND_PEEK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POP  = 2'd2;

    // response status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_PRIO  = 2'd3;

    // which levels the occupancy and head pointer memories are read at
    typedef enum logic [1:0] {
        ADDR_OP,
        ADDR_REPORT,
        ADDR_SWEEP
    } t_addr_sel;

    // controller to datapath commands
    typedef struct packed {
        logic      latch;
        t_addr_sel addr_sel;
        logic      op_lock;
        logic      modify;
        logic      report_lock;
        logic      rep_read;
        logic      build;
        logic      sum_clear;
        logic      sum_add;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic sweep_last;
        logic out_free;
    } t_sts;

endpackage

// ----- hdl/spq_channels.sv -----
// request and response channel interfaces
interface spq_req_if;
    logic                        valid;
    logic                        ready;
    logic [spq_pkg::KIND_W-1:0]  kind;
    logic [spq_pkg::TID_W-1:0]   task_id;
    logic [spq_pkg::PRIO_W-1:0]  priority_req;

    modport source (output valid, kind, task_id, priority_req, input ready);
    modport sink   (input valid, kind, task_id, priority_req, output ready);
endinterface

interface spq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         head_valid;
    logic [spq_pkg::TID_W-1:0]    head_task_id;
    logic [spq_pkg::PRIO_W-1:0]   head_priority;
    logic [spq_pkg::TOTC_W-1:0]   total_count;
    logic [spq_pkg::LVLC_W-1:0]   level_count;
    logic [spq_pkg::STATUS_W-1:0] status;

    modport source (output valid, head_valid, head_task_id, head_priority, total_count,
                    level_count, status, input ready);
    modport sink   (input valid, head_valid, head_task_id, head_priority, total_count,
                    level_count, status, output ready);
endinterface

// ----- hdl/spq_regs.sv -----
// apb configuration register holding the number of active levels
module spq_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spq_pkg::PADDR_W-1:0]   paddr,
    input  logic [spq_pkg::PDATA_W-1:0]   pwdata,
    output logic [spq_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [spq_pkg::CFG_W-1:0]     o_levels,
    output logic                          o_cfg_wr
);

    logic [spq_pkg::CFG_W-1:0] r_levels;
    logic                      w_hit;

    // register decode, word index from the upper address bit
    assign w_hit    = (paddr[spq_pkg::PADDR_W-1] == spq_pkg::REG_LEVELS);
    assign o_cfg_wr = psel && penable && pwrite && w_hit;
    assign pready   = 1'b1;

    // levels in use register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= spq_pkg::LEVELS_RST;
        end else if (o_cfg_wr) begin
            r_levels <= pwdata[spq_pkg::CFG_W-1:0];
        end
    end

    // read back
    assign prdata   = w_hit ? spq_pkg::PDATA_W'(r_levels) : '0;
    assign o_levels = r_levels;

endmodule

// ----- hdl/spq_ctrl.sv -----
// sequencing state machine for requests and the total count recount
module spq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_cfg_wr,
    input  spq_pkg::t_sts i_sts,
    output logic          o_ready,
    output spq_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP,
        S_MOD,
        S_REP,
        S_HRD,
        S_OUT,
        S_SWP_RD,
        S_SWP_ADD
    } t_state;

    t_state r_state, n_state;
    logic   r_dirty, n_dirty;

    assign o_ready = (r_state == S_IDLE) && !r_dirty && !i_cfg_wr;

    // command decode and next state
    always_comb begin
        o_cmd          = '0;
        o_cmd.addr_sel = spq_pkg::ADDR_OP;
        n_state        = r_state;
        n_dirty        = r_dirty;
        case (r_state)
            S_IDLE: begin
                if (r_dirty) begin
                    o_cmd.sum_clear = 1'b1;
                    n_dirty         = 1'b0;
                    n_state         = S_SWP_RD;
                end else if (i_valid && o_ready) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_OP;
                end
            end
            S_OP: begin
                o_cmd.addr_sel = spq_pkg::ADDR_OP;
                o_cmd.op_lock  = 1'b1;
                n_state        = S_MOD;
            end
            S_MOD: begin
                o_cmd.modify = 1'b1;
                n_state      = S_REP;
            end
            S_REP: begin
                o_cmd.addr_sel    = spq_pkg::ADDR_REPORT;
                o_cmd.report_lock = 1'b1;
                n_state           = S_HRD;
            end
            S_HRD: begin
                o_cmd.addr_sel = spq_pkg::ADDR_REPORT;
                o_cmd.rep_read = 1'b1;
                n_state        = S_OUT;
            end
            // keep the report reads steady while the output register is busy
            S_OUT: begin
                o_cmd.addr_sel = spq_pkg::ADDR_REPORT;
                o_cmd.rep_read = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.build = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_SWP_RD: begin
                o_cmd.addr_sel = spq_pkg::ADDR_SWEEP;
                n_state        = S_SWP_ADD;
            end
            S_SWP_ADD: begin
                o_cmd.addr_sel = spq_pkg::ADDR_SWEEP;
                o_cmd.sum_add  = 1'b1;
                n_state        = i_sts.sweep_last ? S_IDLE : S_SWP_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // a register write always forces a recount
        if (i_cfg_wr) begin
            n_dirty = 1'b1;
        end
    end

    // state and recount flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dirty <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dirty <= n_dirty;
        end
    end

endmodule

// ----- hdl/spq_datapath.sv -----
// queue storage, per-level counters, level scan and response register
module spq_datapath #(
    parameter int NUM_LEVELS  = spq_pkg::NUM_LEVELS_DEF,
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  spq_pkg::t_cmd                  i_cmd,
    output spq_pkg::t_sts                  o_sts,
    input  logic [spq_pkg::CFG_W-1:0]      i_levels,
    input  logic [spq_pkg::KIND_W-1:0]     i_kind,
    input  logic [spq_pkg::TID_W-1:0]      i_task_id,
    input  logic [spq_pkg::PRIO_W-1:0]     i_priority_req,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic                           o_head_valid,
    output logic [spq_pkg::TID_W-1:0]      o_head_task_id,
    output logic [spq_pkg::PRIO_W-1:0]     o_head_priority,
    output logic [spq_pkg::TOTC_W-1:0]     o_total_count,
    output logic [spq_pkg::LVLC_W-1:0]     o_level_count,
    output logic [spq_pkg::STATUS_W-1:0]   o_status
);

    localparam int LVL_W  = $clog2(NUM_LEVELS);
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT    = NUM_LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(ENT);
    localparam int TOT_W  = $clog2(ENT + 1);
    localparam int ACT_W  = LVL_W + 1;
    localparam int CMP_W  = (ACT_W > spq_pkg::PRIO_W) ? ACT_W : spq_pkg::PRIO_W;
    localparam int PRI_X  = LVL_W + spq_pkg::PRIO_W;

    // memories
    logic [spq_pkg::TID_W-1:0] store_mem [ENT];
    logic [OCC_W-1:0]          occ_mem   [NUM_LEVELS];
    logic [PTR_W-1:0]          head_mem  [NUM_LEVELS];

    // per-level flags
    logic [NUM_LEVELS-1:0] r_lvl_valid;
    logic [NUM_LEVELS-1:0] r_nonempty;

    // latched request and step results
    logic [spq_pkg::KIND_W-1:0] r_kind;
    logic [spq_pkg::TID_W-1:0]  r_tid;
    logic [spq_pkg::PRIO_W-1:0] r_prio;
    logic [LVL_W-1:0]           r_op_lvl;
    logic                       r_pop_any;
    logic [LVL_W-1:0]           r_rep_lvl;
    logic                       r_rep_any;
    logic                       r_full;
    logic [spq_pkg::TID_W-1:0]  r_pop_tid;
    logic [OCC_W-1:0]           r_lvl_cnt;
    logic [TOT_W-1:0]           r_total;
    logic [LVL_W-1:0]           r_idx;

    // registered read data
    logic [OCC_W-1:0]           r_occ_rd;
    logic                       r_occ_vld;
    logic [PTR_W-1:0]           r_head_rd;
    logic                       r_head_vld;
    logic [spq_pkg::TID_W-1:0]  r_store_rd;

    // response register
    logic                         r_out_valid;
    logic                         r_head_valid;
    logic [spq_pkg::TID_W-1:0]    r_head_tid;
    logic [spq_pkg::PRIO_W-1:0]   r_head_pri;
    logic [spq_pkg::TOTC_W-1:0]   r_tot_out;
    logic [spq_pkg::LVLC_W-1:0]   r_lvl_out;
    logic [spq_pkg::STATUS_W-1:0] r_status;

    logic [CMP_W-1:0]          w_act;
    logic                      w_prio_ok;
    logic [LVL_W-1:0]          w_prio_idx;
    logic [NUM_LEVELS-1:0]     w_elig;
    logic [LVL_W-1:0]          w_top;
    logic                      w_any;
    logic [LVL_W-1:0]          w_occ_addr;
    logic [LVL_W-1:0]          w_head_addr;
    logic [OCC_W-1:0]          w_occ;
    logic [PTR_W-1:0]          w_head;
    logic [OCC_W:0]            w_slot_sum;
    logic [PTR_W-1:0]          w_slot;
    logic [PTR_W-1:0]          w_head_nxt;
    logic                      w_push_eff;
    logic                      w_pop_eff;
    logic [LVL_W-1:0]          w_st_lvl;
    logic [ADDR_W-1:0]         w_st_base;
    logic [ADDR_W-1:0]         w_st_wbase;
    logic [ADDR_W-1:0]         w_st_rd_addr;
    logic [ADDR_W-1:0]         w_st_wr_addr;
    logic                      w_idx_act;
    logic                      w_out_free;
    logic [PRI_X-1:0]          w_pop_pri;
    logic [PRI_X-1:0]          w_rep_pri;
    logic [TOT_W+spq_pkg::TOTC_W-1:0] w_tot_x;
    logic [OCC_W+spq_pkg::LVLC_W-1:0] w_cnt_x;

    // active level count and priority check
    always_comb begin
        if (CMP_W'(i_levels) < CMP_W'(NUM_LEVELS)) begin
            w_act = CMP_W'(i_levels);
        end else begin
            w_act = CMP_W'(NUM_LEVELS);
        end
    end
    assign w_prio_ok  = (r_prio != '0) && (CMP_W'(r_prio) <= w_act);
    assign w_prio_idx = LVL_W'(r_prio - 1'b1);

    // priority encoder over non-empty active levels, highest wins
    always_comb begin
        w_top = '0;
        w_any = 1'b0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            w_elig[i] = r_nonempty[i] && (CMP_W'(i) < w_act);
            if (w_elig[i]) begin
                w_top = LVL_W'(i);
                w_any = 1'b1;
            end
        end
    end

    // read address selection for the level memories
    always_comb begin
        case (i_cmd.addr_sel)
            spq_pkg::ADDR_OP: begin
                w_occ_addr  = (r_kind == spq_pkg::KIND_POP) ? w_top : w_prio_idx;
                w_head_addr = w_occ_addr;
            end
            spq_pkg::ADDR_REPORT: begin
                w_occ_addr  = w_prio_idx;
                w_head_addr = w_top;
            end
            default: begin
                w_occ_addr  = r_idx;
                w_head_addr = r_idx;
            end
        endcase
    end

    // read data, unwritten levels read as empty with head zero
    assign w_occ  = r_occ_vld ? r_occ_rd : '0;
    assign w_head = r_head_vld ? r_head_rd : '0;

    // tail slot and head advance with wrap
    assign w_slot_sum = (OCC_W+1)'(w_head) + (OCC_W+1)'(w_occ);
    always_comb begin
        if (w_slot_sum >= (OCC_W+1)'(QUEUE_DEPTH)) begin
            w_slot = PTR_W'(w_slot_sum - (OCC_W+1)'(QUEUE_DEPTH));
        end else begin
            w_slot = PTR_W'(w_slot_sum);
        end
    end
    assign w_head_nxt = (w_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : w_head + 1'b1;

    // effective operations during the modify step
    assign w_push_eff = (r_kind == spq_pkg::KIND_PUSH) && w_prio_ok &&
                        (w_occ != OCC_W'(QUEUE_DEPTH));
    assign w_pop_eff  = (r_kind == spq_pkg::KIND_POP) && r_pop_any;

    // task store addressing
    assign w_st_lvl     = i_cmd.rep_read ? r_rep_lvl : r_op_lvl;
    assign w_st_base    = ADDR_W'(w_st_lvl) * ADDR_W'(QUEUE_DEPTH);
    assign w_st_wbase   = ADDR_W'(r_op_lvl) * ADDR_W'(QUEUE_DEPTH);
    assign w_st_rd_addr = w_st_base + ADDR_W'(w_head);
    assign w_st_wr_addr = w_st_wbase + ADDR_W'(w_slot);

    // memory ports
    always_ff @(posedge i_clk) begin
        r_occ_rd   <= occ_mem[w_occ_addr];
        r_occ_vld  <= r_lvl_valid[w_occ_addr];
        r_head_rd  <= head_mem[w_head_addr];
        r_head_vld <= r_lvl_valid[w_head_addr];
        r_store_rd <= store_mem[w_st_rd_addr];
        if (i_cmd.modify && w_push_eff) begin
            store_mem[w_st_wr_addr] <= r_tid;
            occ_mem[r_op_lvl]       <= w_occ + 1'b1;
            head_mem[r_op_lvl]      <= w_head;
        end else if (i_cmd.modify && w_pop_eff) begin
            occ_mem[r_op_lvl]  <= w_occ - 1'b1;
            head_mem[r_op_lvl] <= w_head_nxt;
        end
    end

    // level flags and running total
    assign w_idx_act = CMP_W'(r_idx) < w_act;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl_valid <= '0;
            r_nonempty  <= '0;
            r_total     <= '0;
            r_idx       <= '0;
        end else begin
            if (i_cmd.modify && w_push_eff) begin
                r_lvl_valid[r_op_lvl] <= 1'b1;
                r_nonempty[r_op_lvl]  <= 1'b1;
                r_total               <= r_total + 1'b1;
            end else if (i_cmd.modify && w_pop_eff) begin
                r_lvl_valid[r_op_lvl] <= 1'b1;
                r_nonempty[r_op_lvl]  <= (w_occ != OCC_W'(1));
                r_total               <= r_total - 1'b1;
            end else if (i_cmd.sum_clear) begin
                r_total <= '0;
                r_idx   <= '0;
            end else if (i_cmd.sum_add) begin
                if (w_idx_act) begin
                    r_total <= r_total + TOT_W'(w_occ);
                end
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // request and step capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind <= i_kind;
            r_tid  <= i_task_id;
            r_prio <= i_priority_req;
        end
        if (i_cmd.op_lock) begin
            r_op_lvl  <= w_occ_addr;
            r_pop_any <= w_any;
        end
        if (i_cmd.modify) begin
            r_full <= (r_kind == spq_pkg::KIND_PUSH) && w_prio_ok &&
                      (w_occ == OCC_W'(QUEUE_DEPTH));
        end
        if (i_cmd.report_lock) begin
            r_pop_tid <= r_store_rd;
            r_rep_lvl <= w_top;
            r_rep_any <= w_any;
        end
        if (i_cmd.rep_read) begin
            r_lvl_cnt <= w_prio_ok ? w_occ : '0;
        end
    end

    // response fields, counts masked to the field widths
    assign w_pop_pri = PRI_X'(r_op_lvl) + 1'b1;
    assign w_rep_pri = PRI_X'(r_rep_lvl) + 1'b1;
    assign w_tot_x   = (TOT_W+spq_pkg::TOTC_W)'(r_total);
    assign w_cnt_x   = (OCC_W+spq_pkg::LVLC_W)'(r_lvl_cnt);
    assign w_out_free = !r_out_valid || i_out_ready;

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.build) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.build) begin
            if (r_kind == spq_pkg::KIND_POP) begin
                r_head_valid <= r_pop_any;
                r_head_tid   <= r_pop_any ? r_pop_tid : '0;
                r_head_pri   <= r_pop_any ? w_pop_pri[spq_pkg::PRIO_W-1:0] : '0;
            end else begin
                r_head_valid <= r_rep_any;
                r_head_tid   <= r_rep_any ? r_store_rd : '0;
                r_head_pri   <= r_rep_any ? w_rep_pri[spq_pkg::PRIO_W-1:0] : '0;
            end
            r_tot_out <= w_tot_x[spq_pkg::TOTC_W-1:0];
            r_lvl_out <= w_cnt_x[spq_pkg::LVLC_W-1:0];
            if (!w_prio_ok) begin
                r_status <= spq_pkg::ST_BAD_PRIO;
            end else if ((r_kind == spq_pkg::KIND_POP) && !r_pop_any) begin
                r_status <= spq_pkg::ST_POP_EMPTY;
            end else if (r_full) begin
                r_status <= spq_pkg::ST_PUSH_FULL;
            end else begin
                r_status <= spq_pkg::ST_OK;
            end
        end
    end

    assign o_sts.sweep_last = (r_idx == LVL_W'(NUM_LEVELS - 1));
    assign o_sts.out_free   = w_out_free;

    assign o_out_valid     = r_out_valid;
    assign o_head_valid    = r_head_valid;
    assign o_head_task_id  = r_head_tid;
    assign o_head_priority = r_head_pri;
    assign o_total_count   = r_tot_out;
    assign o_level_count   = r_lvl_out;
    assign o_status        = r_status;

    // a non-empty level always has its memory entries written
    a_nonempty_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nonempty & ~r_lvl_valid) == '0)
        else $error("non-empty level without written counters");

    // a response is loaded only into a free output register
    a_build_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.build |-> w_out_free)
        else $error("response overwrites a pending response");

    // the scanned top level really holds tasks when a pop is carried out
    a_pop_occupied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.modify && w_pop_eff) |-> (w_occ != '0))
        else $error("pop from a level whose count is zero");

    // the total follows each accepted push
    a_push_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.modify && w_push_eff) |=> (r_total == $past(r_total) + 1'b1))
        else $error("total count not raised by push");

    // the total follows each pop
    a_pop_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.modify && w_pop_eff) |=> (r_total == $past(r_total) - 1'b1))
        else $error("total count not lowered by pop");

endmodule

// ----- hdl/strict_priority_multi_queue.sv -----
// top level of the strict priority multi-queue
// One request is handled at a time: from acceptance to the response being loaded
// into the output register it passes a chain of registered reads through the
// per-level occupancy and head pointer memories and the task store (look up the
// target level, modify it, look up the new head and the requested level count,
// read the head task). A pending response does not stop the next request from
// being accepted, but it holds back the next response and so any later request.
// After any write to the levels_in_use register the total count is recounted by
// a sweep over all levels that adds up the active ones, during which no request
// is accepted. Pushes to a full level are dropped, pops with no active level
// holding a task report status 1, and a priority of zero or above the active
// level count reports status 3, which takes precedence over the other codes.
module strict_priority_multi_queue #(
    parameter int NUM_LEVELS  = spq_pkg::NUM_LEVELS_DEF,
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    spq_req_if.sink                     i_req,
    spq_rsp_if.source                   o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spq_pkg::PADDR_W-1:0] paddr,
    input  logic [spq_pkg::PDATA_W-1:0] pwdata,
    output logic [spq_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    spq_pkg::t_cmd             w_cmd;
    spq_pkg::t_sts             w_sts;
    logic [spq_pkg::CFG_W-1:0] w_levels;
    logic                      w_cfg_wr;

    // configuration register
    spq_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_levels (w_levels),
        .o_cfg_wr (w_cfg_wr)
    );

    // sequencer
    spq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_req.valid),
        .i_cfg_wr (w_cfg_wr),
        .i_sts    (w_sts),
        .o_ready  (i_req.ready),
        .o_cmd    (w_cmd)
    );

    // storage and response path
    spq_datapath #(
        .NUM_LEVELS  (NUM_LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_levels        (w_levels),
        .i_kind          (i_req.kind),
        .i_task_id       (i_req.task_id),
        .i_priority_req  (i_req.priority_req),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_head_valid    (o_rsp.head_valid),
        .o_head_task_id  (o_rsp.head_task_id),
        .o_head_priority (o_rsp.head_priority),
        .o_total_count   (o_rsp.total_count),
        .o_level_count   (o_rsp.level_count),
        .o_status        (o_rsp.status)
    );

endmodule
